@@ hw/rtl/setq_pkg.sv @@
// Shared types and constants of the scope edge trigger qualifier.
`default_nettype none
package setq_pkg;

    localparam int unsigned SampleWidth   = 12;
    localparam int unsigned PosWidth      = 10;
    localparam int unsigned DefaultDepth  = 1024;

    localparam logic [SampleWidth-1:0] Hysteresis   = 12'd5;
    localparam logic [SampleWidth-1:0] HighClamp    = 12'd4094;
    localparam logic [SampleWidth-1:0] LowFloor     = 12'd1;
    localparam logic [SampleWidth-1:0] LevelReset   = 12'd2048;

    // Phase codes as seen on the result stream.
    localparam logic [1:0] PH_ARMING    = 2'd0;
    localparam logic [1:0] PH_ARMED     = 2'd1;
    localparam logic [1:0] PH_TRIGGERED = 2'd2;

    // Edge codes of the trigger_edge register.
    localparam logic [1:0] EDGE_RISING  = 2'd0;
    localparam logic [1:0] EDGE_FALLING = 2'd1;
    localparam logic [1:0] EDGE_BOTH    = 2'd2;

    // Configuration register indexes.
    localparam logic REG_LEVEL = 1'b0;
    localparam logic REG_EDGE  = 1'b1;

    // Input command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REARM  = 1'b1;

    typedef struct packed {
        logic [SampleWidth-1:0] low;
        logic [SampleWidth-1:0] high;
        logic                   falling;
    } t_thresholds;

    typedef struct packed {
        logic [1:0]          phase;
        logic                pulse;
        logic [PosWidth-1:0] position;
    } t_result;

endpackage
`default_nettype wire

@@ hw/rtl/scope_edge_trigger_qualifier_core.sv @@
// Top level of the scope edge trigger qualifier: stream ports and result register.
// Each sample beat on the slave stream yields one result beat on the master stream, in the
// cycle after it is taken. The block sustains one beat per clock: the phase sequencer
// updates in the cycle a beat is accepted and the result sits in a single output register,
// so a new beat is taken whenever that register is empty or being drained in the same cycle.
// The trigger arms after two consecutive samples beyond the level on the far side of the
// band (level minus five for rising, plus five for falling), then fires after two
// consecutive samples across the other side; a beat with tuser high rearms and clears the
// sample counter. Configuration writes apply from the next sample and must be made with
// the stream idle.
`default_nettype none
module scope_edge_trigger_qualifier_core
    import setq_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = DefaultDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [11:0] i_cfg_data,
    // Slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [11:0] sample, [15:12] zero
    input  wire logic        s_axis_tuser,  // [0] command
    // Master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // [1:0] phase, [2] trigger_pulse,
                                            // [12:3] trigger_position, [15:13] zero
);

    t_thresholds thr;
    t_result     result;
    t_result     r_result;
    logic        r_valid;
    logic        s_accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    setq_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_thr      (thr)
    );

    setq_qualifier #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_qual (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (s_accept),
        .i_command (s_axis_tuser),
        .i_sample  (s_axis_tdata[SampleWidth-1:0]),
        .i_thr     (thr),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_accept) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_result <= result;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {3'b000, r_result.position, r_result.pulse, r_result.phase};

`ifndef SYNTHESIS
    // A trigger pulse only ever comes with the triggered phase.
    a_pulse_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[1:0] == PH_TRIGGERED))
        else $error("trigger pulse outside triggered phase");

    // A rearm beat always yields arming with position cleared.
    a_rearm_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_axis_tuser == CMD_REARM) |=>
        (m_axis_tvalid && m_axis_tdata[12:0] == 13'd0))
        else $error("rearm did not clear the result");

    // The input stalls only while a result is held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");

    // Outside the triggered phase the position reads as zero.
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != PH_TRIGGERED) |-> (m_axis_tdata[12:3] == 10'd0))
        else $error("position set outside triggered phase");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/setq_cfg_regs.sv @@
// Configuration registers and hysteresis threshold derivation.
`default_nettype none
module setq_cfg_regs
    import setq_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_wr_en,
    input  wire logic                   i_wr_index,
    input  wire logic [SampleWidth-1:0] i_wr_data,
    output t_thresholds                 o_thr
);

    logic [SampleWidth-1:0] r_level;
    logic [1:0]             r_edge;
    logic [SampleWidth:0]   sum_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LevelReset;
            r_edge  <= EDGE_RISING;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_LEVEL: r_level <= i_wr_data;
                REG_EDGE:  r_edge  <= i_wr_data[1:0];
                default:   r_level <= r_level;
            endcase
        end
    end

    assign sum_high = {1'b0, r_level} + {1'b0, Hysteresis};

    always_comb begin
        // A level below the hysteresis band floors the low bound at one.
        o_thr.low  = (r_level < Hysteresis) ? LowFloor : (r_level - Hysteresis);
        o_thr.high = (sum_high > {1'b0, HighClamp}) ? HighClamp : sum_high[SampleWidth-1:0];
        // Both-edge mode and the unused code behave as rising.
        o_thr.falling = (r_edge == EDGE_FALLING);
    end

endmodule
`default_nettype wire

@@ hw/rtl/setq_qualifier.sv @@
// Trigger phase sequencer with two-sample qualification and sample counter.
`default_nettype none
module setq_qualifier
    import setq_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = DefaultDepth
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_command,
    input  wire logic [SampleWidth-1:0] i_sample,
    input  wire t_thresholds            i_thr,
    output t_result                     o_result
);

    localparam int unsigned CntWidth = $clog2(BUFFER_DEPTH);
    localparam int unsigned ExtWidth = (CntWidth > PosWidth) ? CntWidth : PosWidth;

    typedef enum logic [1:0] {
        ST_ARMING    = PH_ARMING,
        ST_ARMED     = PH_ARMED,
        ST_TRIGGERED = PH_TRIGGERED
    } t_phase;

    t_phase              r_phase, n_phase;
    logic                r_prev_met, n_prev_met;
    logic [CntWidth-1:0] r_cnt, n_cnt;
    logic [CntWidth-1:0] r_held, n_held;
    logic                met;
    logic                pulse;
    logic [ExtWidth-1:0] held_ext;

    always_comb begin
        met = 1'b0;
        unique case (r_phase)
            ST_ARMING: met = i_thr.falling ? (i_sample > i_thr.high) : (i_sample < i_thr.low);
            ST_ARMED:  met = i_thr.falling ? (i_sample <= i_thr.low) : (i_sample >= i_thr.high);
            default:   met = 1'b0;
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_prev_met = r_prev_met;
        n_cnt      = r_cnt;
        n_held     = r_held;
        pulse      = 1'b0;
        if (i_command == CMD_REARM) begin
            n_phase    = ST_ARMING;
            n_prev_met = 1'b0;
            n_cnt      = '0;
            n_held     = '0;
        end else begin
            if (r_phase != ST_TRIGGERED) begin
                if (met && r_prev_met) begin
                    // A completed pair ends the phase; the next pair starts afresh.
                    n_prev_met = 1'b0;
                    if (r_phase == ST_ARMING) begin
                        n_phase = ST_ARMED;
                    end else begin
                        n_phase = ST_TRIGGERED;
                        n_held  = r_cnt;
                        pulse   = 1'b1;
                    end
                end else begin
                    n_prev_met = met;
                end
            end
            n_cnt = (r_cnt == CntWidth'(BUFFER_DEPTH - 1)) ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ST_ARMING;
            r_prev_met <= 1'b0;
            r_cnt      <= '0;
            r_held     <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_prev_met <= n_prev_met;
            r_cnt      <= n_cnt;
            r_held     <= n_held;
        end
    end

    assign held_ext = ExtWidth'(n_held);

    always_comb begin
        o_result.phase    = n_phase;
        o_result.pulse    = pulse;
        o_result.position = (n_phase == ST_TRIGGERED) ? held_ext[PosWidth-1:0] : '0;
    end

endmodule
`default_nettype wire
